// ===== sv/sstr_pkg.sv =====
`default_nettype none

package sstr_pkg;

   localparam int unsigned DIGIT_COUNT_DEFAULT = 4;

   localparam logic [7:0] CMD_CLEAR    = 8'd2;
   localparam logic [7:0] CMD_SEGMENTS = 8'd3;
   localparam logic [7:0] CMD_POINT    = 8'd5;

   localparam logic [2:0] LEN_SHORT = 3'd2;
   localparam logic [2:0] LEN_LONG  = 3'd4;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_POINT = 8'h2e;

   localparam int unsigned FONT_FIRST = 45;
   localparam int unsigned FONT_SIZE  = 78;
   localparam int unsigned FONT_IDX_W = $clog2(FONT_SIZE);

   // glyphs for '-' to 'z'
   localparam logic [7:0] FONT_TABLE [FONT_SIZE] = '{
      8'h40, 8'h80, 8'h00,
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
      8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h00, 8'h00,
      8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h00, 8'h76, 8'h30,
      8'h0e, 8'h00, 8'h38, 8'h00, 8'h37, 8'h5c, 8'h73, 8'h00, 8'h50,
      8'h00, 8'h00, 8'h3e, 8'h1c, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
      8'h5f, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h00, 8'h74, 8'h30,
      8'h0e, 8'h00, 8'h38, 8'h00, 8'h54, 8'h5c, 8'h73, 8'h00, 8'h50,
      8'h00, 8'h00, 8'h3e, 8'h1c, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic [7:0] address_byte;
      logic [7:0] command_byte;
      logic [3:0] digit_index;
      logic [7:0] payload;
      logic [2:0] message_length;
   } message_type;

   function automatic logic [7:0] font_glyph(input logic [7:0] code);
      logic [7:0] offset;
      logic [7:0] glyph;
      offset = code - 8'(FONT_FIRST);
      if (code >= 8'(FONT_FIRST) && offset < 8'(FONT_SIZE)) begin
         glyph = FONT_TABLE[offset[FONT_IDX_W-1:0]];
      end else begin
         glyph = 8'h00;
      end
      return glyph;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sstr_channels.sv =====
`default_nettype none

interface sstr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] character;
   logic [2:0] start_position;

   modport source(output valid, mode, character, start_position, input ready);
   modport sink(input valid, mode, character, start_position, output ready);
endinterface

interface sstr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] address_byte;
   logic [7:0] command_byte;
   logic [3:0] digit_index;
   logic [7:0] payload;
   logic [2:0] message_length;

   modport source(output valid, address_byte, command_byte, digit_index, payload,
                  message_length, input ready);
   modport sink(input valid, address_byte, command_byte, digit_index, payload,
                message_length, output ready);
endinterface

interface sstr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/seven_segment_text_renderer_core.sv =====
// An accepted transfer's message is registered and appears on rsp in the cycle after.
// Throughput: one item per cycle; req stalls only while a message waits unread.
// Items that produce no message update state and leave rsp untouched.
// Reset (synchronous, high): position, start and armed flag cleared, rsp empty,
// device address 0.
`default_nettype none

module seven_segment_text_renderer_core #(
   parameter int unsigned DIGIT_COUNT = sstr_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sstr_req_if.sink   req,
   sstr_rsp_if.source rsp,
   sstr_csr_if.sink   csr
);
   import sstr_pkg::*;

   localparam logic [3:0] LAST_DIGIT = 4'(DIGIT_COUNT - 1);

   logic [7:0]  address_ff;
   logic [3:0]  current_ff, current_in;
   logic [3:0]  first_ff, first_in;
   logic        active_ff, active_in;
   logic        rsp_valid_ff;
   message_type rsp_msg_ff, rsp_msg_in;
   logic        emit;
   logic        accept;
   logic [3:0]  previous;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign previous  = current_ff - 4'd1;

   always_comb begin
      emit       = 1'b0;
      current_in = current_ff;
      first_in   = first_ff;
      active_in  = active_ff;
      rsp_msg_in = '{address_byte:   address_ff,
                     command_byte:   CMD_SEGMENTS,
                     digit_index:    current_ff,
                     payload:        font_glyph(req.character),
                     message_length: LEN_LONG};
      if (req.mode) begin
         current_in = {1'b0, req.start_position};
         first_in   = {1'b0, req.start_position};
         active_in  = 1'b1;
         emit       = 1'b1;
         rsp_msg_in.command_byte   = CMD_CLEAR;
         rsp_msg_in.digit_index    = 4'd0;
         rsp_msg_in.payload        = 8'h00;
         rsp_msg_in.message_length = LEN_SHORT;
      end else if (active_ff) begin
         if (req.character == CHAR_END || current_ff > LAST_DIGIT) begin
            active_in = 1'b0;
         end else if (req.character == CHAR_POINT) begin
            // point goes on the digit before, never before the start
            if (current_ff != 4'd0 && previous >= first_ff) begin
               emit = 1'b1;
               rsp_msg_in.command_byte = CMD_POINT;
               rsp_msg_in.digit_index  = previous;
               rsp_msg_in.payload      = 8'h01;
            end
         end else begin
            emit       = 1'b1;
            current_in = current_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= 8'h00;
         current_ff   <= 4'd0;
         first_ff     <= 4'd0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            address_ff <= csr.data;
         end
         if (accept) begin
            current_ff   <= current_in;
            first_ff     <= first_in;
            active_ff    <= active_in;
            rsp_valid_ff <= emit;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_msg_ff <= rsp_msg_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.address_byte   = rsp_msg_ff.address_byte;
   assign rsp.command_byte   = rsp_msg_ff.command_byte;
   assign rsp.digit_index    = rsp_msg_ff.digit_index;
   assign rsp.payload        = rsp_msg_ff.payload;
   assign rsp.message_length = rsp_msg_ff.message_length;

`ifndef ASSERT_OFF
   a_begin_arms: assert property (@(posedge clock) disable iff (reset)
      accept && req.mode |=> active_ff && current_ff == first_ff && rsp_valid_ff
                             && rsp.command_byte == CMD_CLEAR)
      else $error("begin transfer did not arm the renderer");

   a_clear_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp.command_byte == CMD_CLEAR |->
         rsp.message_length == LEN_SHORT && rsp.digit_index == 4'd0
         && rsp.payload == 8'h00)
      else $error("malformed clear message");

   a_point_before_cursor: assert property (@(posedge clock) disable iff (reset)
      accept && !req.mode && emit && req.character == CHAR_POINT |=>
         rsp.command_byte == CMD_POINT && rsp.payload == 8'h01
         && rsp.digit_index == current_ff - 4'd1 && rsp.digit_index >= first_ff)
      else $error("decimal point on wrong digit");

   a_segment_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !req.mode && emit && req.character != CHAR_POINT |=>
         current_ff == $past(current_ff) + 4'd1
         && rsp.digit_index == $past(current_ff)
         && rsp.digit_index <= LAST_DIGIT)
      else $error("segment write did not advance the position");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && !req.mode && !active_ff |=> !rsp_valid_ff && !active_ff)
      else $error("message produced while not armed");
`endif

endmodule

`default_nettype wire
